// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// shared types, constants and bit-mapping functions of the secded 40/32 codec
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int CwBits   = 40;
	localparam int DataBits = 32;
	localparam int SynBits  = 6;

	// codeword bit of hamming position p is bit CwBits-1-p
	localparam logic [CwBits-1:0] RESERVED_CLEAR = 40'hEF_FFFF_FFFF;
	localparam int OverallBit = CwBits - 1;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [1:0] STAT_CLEAN   = 2'd0;
	localparam logic [1:0] STAT_CORR    = 2'd1;
	localparam logic [1:0] STAT_UNCORR  = 2'd2;

	// stage 1: word ready for checking
	typedef struct packed {
		logic              vld;
		logic              op;
		logic [CwBits-1:0] word;
	} sdc_st1_t;

	// stage 2: word with its syndrome and overall parity
	typedef struct packed {
		logic               vld;
		logic               op;
		logic [CwBits-1:0]  word;
		logic [SynBits-1:0] syn;
		logic               par;
	} sdc_st2_t;

	// data bits into their codeword positions, check positions left zero
	function automatic logic [CwBits-1:0] place_data(input logic [DataBits-1:0] d);
		logic [CwBits-1:0] c;
		c        = '0;
		c[6:0]   = d[6:0];
		c[22:8]  = d[21:7];
		c[30:24] = d[28:22];
		c[34:32] = d[31:29];
		return c;
	endfunction

	// gather data positions back into a data word
	function automatic logic [DataBits-1:0] take_data(input logic [CwBits-1:0] c);
		return {c[34:32], c[30:24], c[22:8], c[6:0]};
	endfunction

	// xor of hamming positions 1..39 whose bit is set
	function automatic logic [SynBits-1:0] syndrome_of(input logic [CwBits-1:0] c);
		logic [SynBits-1:0] s;
		s = '0;
		for (int p = 1; p < CwBits; p++) begin
			if (c[CwBits-1-p])
				s ^= SynBits'(p);
		end
		return s;
	endfunction

endpackage

// ===== src/sdc_prep.sv =====
// ----------------------------------------------------------------------------
// sdc_prep
// stage 1: places data for encode or clears the reserved bit for decode
// ----------------------------------------------------------------------------
module sdc_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  logic                          op,
	input  logic [sdc_pkg::DataBits-1:0]  data_in,
	input  logic [sdc_pkg::CwBits-1:0]    code_in,
	output sdc_pkg::sdc_st1_t             st_s1
);
	import sdc_pkg::*;

	logic [CwBits-1:0] word;

	assign word = (op == OP_DECODE) ? (code_in & RESERVED_CLEAR) : place_data(data_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			st_s1.vld  <= vld;
			st_s1.op   <= op;
			st_s1.word <= word;
		end
	end

endmodule

// ===== src/sdc_synd.sv =====
// ----------------------------------------------------------------------------
// sdc_synd
// stage 2: syndrome and overall parity xor trees
// ----------------------------------------------------------------------------
module sdc_synd (
	input  logic              clk,
	input  logic              arst_n,
	input  sdc_pkg::sdc_st1_t st_s1,
	output sdc_pkg::sdc_st2_t st_s2
);
	import sdc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else begin
			st_s2.vld  <= st_s1.vld;
			st_s2.op   <= st_s1.op;
			st_s2.word <= st_s1.word;
			st_s2.syn  <= syndrome_of(st_s1.word);
			st_s2.par  <= ^st_s1.word;
		end
	end

endmodule

// ===== src/sdc_fix.sv =====
// ----------------------------------------------------------------------------
// sdc_fix
// stage 3: inserts check bits on encode, classifies and corrects on decode
// ----------------------------------------------------------------------------
module sdc_fix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdc_pkg::sdc_st2_t             st_s2,
	output logic                          vld_s3,
	output logic                          op_s3,
	output logic [sdc_pkg::CwBits-1:0]    code_s3,
	output logic [sdc_pkg::DataBits-1:0]  data_s3,
	output logic [1:0]                    status_s3
);
	import sdc_pkg::*;

	logic [CwBits-1:0] enc_word;
	logic [CwBits-1:0] flip_mask;
	logic [CwBits-1:0] dec_word;
	logic [1:0]        dec_status;

	// encode: check bit 2^k takes syndrome bit k, overall bit evens the word
	always_comb begin
		enc_word = st_s2.word;
		for (int k = 0; k < SynBits; k++)
			enc_word[CwBits-1-(1 << k)] = st_s2.syn[k];
		enc_word[OverallBit] = st_s2.par ^ (^st_s2.syn);
	end

	// decode classification and single-bit flip
	always_comb begin
		flip_mask = '0;
		if (st_s2.syn == '0) begin
			dec_status = STAT_CLEAN;
		end else if (!st_s2.par) begin
			dec_status = STAT_UNCORR;
		end else begin
			dec_status = STAT_CORR;
			if (st_s2.syn < SynBits'(CwBits))
				flip_mask[SynBits'(CwBits - 1) - st_s2.syn] = 1'b1;
		end
		dec_word = st_s2.word ^ flip_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= st_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		op_s3 <= st_s2.op;
		if (st_s2.op == OP_DECODE) begin
			code_s3   <= dec_word;
			data_s3   <= take_data(dec_word);
			status_s3 <= dec_status;
		end else begin
			code_s3   <= enc_word;
			data_s3   <= '0;
			status_s3 <= STAT_CLEAN;
		end
	end

endmodule

// ===== src/secded_40_32_codec_top.sv =====
// ----------------------------------------------------------------------------
// secded_40_32_codec_top
// secded (40,32) hamming encoder and decoder, three-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   command channel: start high with busy low is a transfer of op, data_in
//   and code_in. op 0 encodes data_in, op 1 decodes code_in.
//   busy is tied low: the pipeline never stalls, so a new command may be
//   issued in every cycle.
//   result channel: done is high for exactly one cycle with code_out,
//   data_out and status; that cycle is the transfer, the receiver cannot
//   hold it off.
//   stages: a command passes the three register stages in order up to done
//   (prepare word, syndrome and parity trees, correct and format).
//   throughput: 1 item per cycle, results come out in command order.
//   reset: arst_n clears the first two stages and the valid bit of the
//   output stage, so items in flight are dropped and no done follows; the
//   output payload registers are not reset.
// ----------------------------------------------------------------------------
module secded_40_32_codec_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] data_in,
	input  logic [39:0] code_in,
	output logic        done,
	output logic [39:0] code_out,
	output logic [31:0] data_out,
	output logic [1:0]  status
);
	import sdc_pkg::*;

	sdc_st1_t st_s1;
	sdc_st2_t st_s2;
	logic     op_s3;

	// no back pressure anywhere, so commands are always taken
	assign busy = 1'b0;

	// stage 1: data placement or reserved-bit clear
	sdc_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.op      (op),
		.data_in (data_in),
		.code_in (code_in),
		.st_s1   (st_s1)
	);

	// stage 2: syndrome and parity
	sdc_synd u_synd (
		.clk    (clk),
		.arst_n (arst_n),
		.st_s1  (st_s1),
		.st_s2  (st_s2)
	);

	// stage 3: check bit insertion or correction, output register
	sdc_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.st_s2     (st_s2),
		.vld_s3    (done),
		.op_s3     (op_s3),
		.code_s3   (code_out),
		.data_s3   (data_out),
		.status_s3 (status)
	);

	// every command transfer yields exactly one result once it has passed all register stages
	assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && $past(arst_n) && $past(arst_n, 2) && $past(arst_n, 3))
		|-> (done == $past(start, 3)))
		else $error("result strobe does not follow command by three cycles");

	// encode results always report clean status and zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_s3 == OP_ENCODE) |-> (status == STAT_CLEAN && data_out == '0))
		else $error("encode result carries decode fields");

	// decoded data is the data field of the corrected codeword
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_s3 == OP_DECODE) |-> (data_out == take_data(code_out)))
		else $error("decoded data does not match corrected codeword");

	// status never takes the unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_CLEAN || status == STAT_CORR || status == STAT_UNCORR))
		else $error("status out of range");

endmodule

// ===== tb/sv/secded_40_32_codec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secded_40_32_codec_checker
// watches both channels of the codec, predicts each result from the accepted
// command and compares it field by field, in order, with what comes out
// ----------------------------------------------------------------------------
module secded_40_32_codec_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        op,
	input  logic [31:0] data_in,
	input  logic [39:0] code_in,
	input  logic        done,
	input  logic [39:0] code_out,
	input  logic [31:0] data_out,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending,
	output int          n_encode,
	output int          n_clean,
	output int          n_corrected,
	output int          n_uncorr
);
	import sdc_pkg::*;

	localparam int ParBit  = 39;   // hamming position 0
	localparam int ResvBit = 36;   // hamming position 3

	typedef struct packed {
		logic [39:0] code;
		logic [31:0] data;
		logic [1:0]  stat;
	} codec_out_t;

	codec_out_t awaited_outputs[$];

	// codeword bits that carry data: not overall parity, not reserved, not a power of two
	function automatic bit data_slot(input int b);
		int p;
		p = 39 - b;
		return (p != 0) && (p != 3) && ((p & (p - 1)) != 0);
	endfunction

	function automatic logic [39:0] spread_data(input logic [31:0] d);
		logic [39:0] w;
		int          k;
		w = '0;
		k = 0;
		for (int b = 0; b < 40; b++)
			if (data_slot(b)) begin
				w[b] = d[k];
				k++;
			end
		return w;
	endfunction

	function automatic logic [31:0] gather_data(input logic [39:0] w);
		logic [31:0] d;
		int          k;
		d = '0;
		k = 0;
		for (int b = 0; b < 40; b++)
			if (data_slot(b)) begin
				d[k] = w[b];
				k++;
			end
		return d;
	endfunction

	// xor of the hamming positions 1..39 that are set
	function automatic logic [5:0] check_sum(input logic [39:0] w);
		logic [5:0] s;
		s = '0;
		for (int b = 0; b < 39; b++)
			if (w[b])
				s ^= 6'(39 - b);
		return s;
	endfunction

	function automatic logic [39:0] secded_encode(input logic [31:0] d);
		logic [39:0] w;
		logic [5:0]  s;
		w = spread_data(d);
		s = check_sum(w);
		for (int k = 0; k < 6; k++)
			if (s[k])
				w[39 - (1 << k)] = 1'b1;
		w[ParBit] = ^w;
		return w;
	endfunction

	function automatic codec_out_t secded_decode(input logic [39:0] c);
		codec_out_t r;
		logic [5:0] s;
		int         idx;
		r.code          = c;
		r.code[ResvBit] = 1'b0;
		s               = check_sum(r.code);
		idx             = 39 - int'(s);
		if (s == '0) begin
			r.stat = STAT_CLEAN;
		end else if (!(^r.code)) begin
			r.stat = STAT_UNCORR;
		end else begin
			r.stat = STAT_CORR;
			if (s < 6'd40)
				r.code[idx] = ~r.code[idx];
		end
		r.data = gather_data(r.code);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		codec_out_t want;
		if (!arst_n) begin
			awaited_outputs.delete();
			fail_count  <= 0;
			pending     <= 0;
			n_encode    <= 0;
			n_clean     <= 0;
			n_corrected <= 0;
			n_uncorr    <= 0;
		end else begin
			if (start && !busy) begin
				if (op == OP_ENCODE) begin
					want = '{code: secded_encode(data_in), data: '0, stat: STAT_CLEAN};
					n_encode <= n_encode + 1;
				end else begin
					want = secded_decode(code_in);
					case (want.stat)
						STAT_CLEAN: n_clean     <= n_clean + 1;
						STAT_CORR:  n_corrected <= n_corrected + 1;
						default:    n_uncorr    <= n_uncorr + 1;
					endcase
				end
				awaited_outputs.push_back(want);
			end
			if (done) begin
				if (awaited_outputs.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing outstanding: code %h data %h status %0d",
							$time, code_out, data_out, status);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_outputs.pop_front();
					if (code_out !== want.code || data_out !== want.data ||
							status !== want.stat) begin
						if (fail_count < 10)
							$display("%0t: mismatch: want code %h data %h status %0d",
								$time, want.code, want.data, want.stat,
								", got code %h data %h status %0d",
								code_out, data_out, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= awaited_outputs.size();
		end
	end

endmodule

// ===== tb/sv/tb_secded_40_32_codec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_secded_40_32_codec_top
// drives encode and decode commands into the codec: a directed set of edge
// patterns and error cases, then random words under three idle profiles;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_secded_40_32_codec_top;
	import sdc_pkg::*;

	localparam int CycleLimit = 400000;   // far above the slowest correct run
	localparam int PhaseItems = 450;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [31:0] data_in;
	logic [39:0] code_in;
	logic        done;
	logic [39:0] code_out;
	logic [31:0] data_out;
	logic [1:0]  status;

	int fail_count;
	int pending;
	int n_encode;
	int n_clean;
	int n_corrected;
	int n_uncorr;
	int idle_pct;
	int cycle_cnt = 0;

	always #5 clk = ~clk;

	secded_40_32_codec_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.data_in  (data_in),
		.code_in  (code_in),
		.done     (done),
		.code_out (code_out),
		.data_out (data_out),
		.status   (status)
	);

	secded_40_32_codec_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.data_in     (data_in),
		.code_in     (code_in),
		.done        (done),
		.code_out    (code_out),
		.data_out    (data_out),
		.status      (status),
		.fail_count  (fail_count),
		.pending     (pending),
		.n_encode    (n_encode),
		.n_clean     (n_clean),
		.n_corrected (n_corrected),
		.n_uncorr    (n_uncorr)
	);

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one-hot mask of a hamming position
	function automatic logic [39:0] pos_bit(input int p);
		return 40'h1 << (39 - p);
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	// with start still high, so back-to-back commands never toggle start
	task automatic send_cmd(input logic o, input logic [31:0] d, input logic [39:0] c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		op      <= o;
		data_in <= d;
		code_in <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] d;
		logic [39:0] base;
		logic [39:0] junk;
		int          kind;
		int          p1;
		int          p2;
		int          p3;

		// every input known from time zero
		arst_n   = 1'b0;
		start    = 1'b0;
		op       = OP_ENCODE;
		data_in  = '0;
		code_in  = '0;
		idle_pct = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: encode corner words, ignored code_in swung to both extremes
		send_cmd(OP_ENCODE, 32'h0000_0000, 40'hFF_FFFF_FFFF);
		send_cmd(OP_ENCODE, 32'hFFFF_FFFF, 40'h00_0000_0000);
		send_cmd(OP_ENCODE, 32'h5555_5555, 40'hAA_AAAA_AAAA);
		send_cmd(OP_ENCODE, 32'hAAAA_AAAA, 40'h55_5555_5555);
		send_cmd(OP_ENCODE, 32'h0000_0001, '0);
		send_cmd(OP_ENCODE, 32'h8000_0000, '0);

		// directed decode: all-zero and all-one received words
		send_cmd(OP_DECODE, 32'hFFFF_FFFF, 40'h00_0000_0000);
		send_cmd(OP_DECODE, 32'h0000_0000, 40'hFF_FFFF_FFFF);

		base = u_chk.secded_encode(32'hC3A5_0F96);
		send_cmd(OP_DECODE, '0, base);                                 // clean word
		send_cmd(OP_DECODE, '0, base ^ pos_bit(0));                    // overall parity alone
		send_cmd(OP_DECODE, '0, base ^ pos_bit(3));                    // reserved bit alone
		send_cmd(OP_DECODE, '0, base ^ pos_bit(3) ^ pos_bit(21));      // reserved ignored, data fixed
		send_cmd(OP_DECODE, '0, base ^ pos_bit(39));                   // last data position
		send_cmd(OP_DECODE, '0, base ^ pos_bit(5));                    // first data position
		send_cmd(OP_DECODE, '0, base ^ pos_bit(1));                    // lowest check bit
		send_cmd(OP_DECODE, '0, base ^ pos_bit(32));                   // highest check bit
		send_cmd(OP_DECODE, '0, base ^ pos_bit(7) ^ pos_bit(30));      // double error
		send_cmd(OP_DECODE, '0, base ^ pos_bit(0) ^ pos_bit(5));       // double incl. parity bit
		// syndrome beyond the word with odd parity: corrected, nothing flipped
		send_cmd(OP_DECODE, '0, base ^ pos_bit(32) ^ pos_bit(8) ^ pos_bit(1));
		send_cmd(OP_DECODE, '0, base ^ pos_bit(0) ^ pos_bit(1) ^ pos_bit(2) ^ pos_bit(4)
			^ pos_bit(8) ^ pos_bit(16) ^ pos_bit(32));
		// same syndrome with even parity: uncorrectable
		send_cmd(OP_DECODE, '0, base ^ pos_bit(1) ^ pos_bit(2) ^ pos_bit(4)
			^ pos_bit(8) ^ pos_bit(16) ^ pos_bit(32));
		// syndrome pointing at the reserved bit: it comes back set in code_out
		send_cmd(OP_DECODE, '0, base ^ pos_bit(0) ^ pos_bit(1) ^ pos_bit(2));

		// random part, three idle profiles: light, heavy, none
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 22 : (phase == 1) ? 70 : 0;
			for (int n = 0; n < PhaseItems; n++) begin
				kind = $urandom_range(99);
				d    = $urandom;
				if ($urandom_range(15) == 0)
					d = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				junk = {8'($urandom), 32'($urandom)};
				base = u_chk.secded_encode(d);
				p1   = $urandom_range(39);
				p2   = (p1 + 1 + $urandom_range(38)) % 40;
				p3   = $urandom_range(39);
				if (kind < 35)
					send_cmd(OP_ENCODE, d, junk);
				else if (kind < 48)
					send_cmd(OP_DECODE, junk[31:0], base);
				else if (kind < 70)
					send_cmd(OP_DECODE, junk[31:0], base ^ pos_bit(p1));
				else if (kind < 84)
					send_cmd(OP_DECODE, junk[31:0], base ^ pos_bit(p1) ^ pos_bit(p2));
				else if (kind < 92)
					send_cmd(OP_DECODE, junk[31:0],
						base ^ pos_bit(p1) ^ pos_bit(p2) ^ pos_bit(p3));
				else
					send_cmd(OP_DECODE, d, junk);   // arbitrary received word
			end
		end
		start <= 1'b0;

		// drain the pipeline, then give stray results a few cycles to show up
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d encodes and %0d decodes", n_encode,
			n_clean + n_corrected + n_uncorr);
		$display("decode outcomes: %0d clean, %0d corrected, %0d uncorrectable, %0d failures",
			n_clean, n_corrected, n_uncorr, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/sdc_pkg.sv
src/sdc_prep.sv
src/sdc_synd.sv
src/sdc_fix.sv
src/secded_40_32_codec_top.sv
tb/sv/secded_40_32_codec_checker.sv
tb/sv/tb_secded_40_32_codec_top.sv
